// File: rtl/core/twba_pkg.sv
// ----------------------------------------------------------------------------
// twba_pkg
// Shared types and constants for the table with bulk assign and point add.
// ----------------------------------------------------------------------------
package twba_pkg;

  // field widths
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 64;
  localparam int REQ_W     = 2;
  localparam int S_TDATA_W = 80;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ASSIGN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  // epoch tags: tag zero marks a dead entry after a sweep
  localparam int                 EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_DEAD  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } req_t;

  // core status toward the request handshake
  typedef struct packed {
    logic clearing;
    logic wrap_hold;
    logic read_pending;
  } core_status_t;

endpackage

// File: rtl/core/twba_out_fifo.sv
// ----------------------------------------------------------------------------
// twba_out_fifo
// Small result queue between the table core and the output stream.
// ----------------------------------------------------------------------------
module twba_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [twba_pkg::VALUE_W-1:0] push_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [twba_pkg::VALUE_W-1:0] m_tdata,
  output logic [twba_pkg::CNT_W-1:0]   count
);
  import twba_pkg::*;

  logic [VALUE_W-1:0] data [OUT_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic               pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = data[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      data[wptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// File: rtl/core/twba_core.sv
// ----------------------------------------------------------------------------
// twba_core
// Entry memory with epoch tags, read-modify-write stage with forwarding,
// base register and the tag sweep.
// ----------------------------------------------------------------------------
module twba_core #(
  parameter int ENTRIES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  twba_pkg::req_t               req,
  output logic                         res_valid,
  output logic [twba_pkg::VALUE_W-1:0] res_value,
  output twba_pkg::core_status_t       status
);
  import twba_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [VALUE_W-1:0] sum;
  } word_t;

  word_t mem [ENTRIES];

  // request address decode
  logic [INDEX_W+AW-1:0] in_wide;
  logic [AW-1:0]         in_addr;
  logic                  in_range;

  assign in_wide  = (INDEX_W+AW)'(req.index);
  assign in_addr  = in_wide[AW-1:0];
  assign in_range = 32'(req.index) < 32'(ENTRIES);

  // stage registers
  logic               s1_valid;
  logic [REQ_W-1:0]   s1_type;
  logic [AW-1:0]      s1_addr;
  logic               s1_in_range;
  logic [VALUE_W-1:0] s1_value;
  word_t              rd_word;
  logic               fwd_hit;
  word_t              fwd_word;

  // table state
  logic [EPOCH_W-1:0] epoch;
  logic [VALUE_W-1:0] base;
  logic               clearing;
  logic [AW-1:0]      sweep_addr;

  // stage logic
  word_t              cur_word;
  logic               live;
  logic [VALUE_W-1:0] sum_old;
  logic               wr_en;
  word_t              wr_word;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  word_t              mem_wdata;

  assign cur_word = fwd_hit ? fwd_word : rd_word;
  assign live     = (cur_word.tag == epoch);
  assign sum_old  = live ? cur_word.sum : '0;
  assign wr_en    = s1_valid && s1_in_range &&
                    ((s1_type == REQ_LOAD) || (s1_type == REQ_ADD));

  always_comb begin
    wr_word.tag = epoch;
    if (s1_type == REQ_LOAD) begin
      wr_word.sum = s1_value;
    end else begin
      wr_word.sum = sum_old + s1_value;
    end
  end

  // read result
  assign res_valid = s1_valid && (s1_type == REQ_READ);
  assign res_value = base + ((s1_in_range && live) ? cur_word.sum : '0);

  // memory write port: sweep has priority, no requests run during it
  always_comb begin
    mem_we    = clearing || wr_en;
    mem_waddr = clearing ? sweep_addr : s1_addr;
    if (clearing) begin
      mem_wdata.tag = EPOCH_DEAD;
      mem_wdata.sum = '0;
    end else begin
      mem_wdata = wr_word;
    end
  end

  // memory access with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (acc) begin
      rd_word <= mem[in_addr];
    end
  end

  // stage payload and forwarding of the write made at the same edge
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_type     <= req.req_type;
      s1_addr     <= in_addr;
      s1_in_range <= in_range;
      s1_value    <= req.value;
      fwd_hit     <= wr_en && (s1_addr == in_addr);
      fwd_word    <= wr_word;
    end
  end

  // control, base, epoch and sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      epoch      <= EPOCH_FIRST;
      base       <= '0;
      clearing   <= 1'b1;
      sweep_addr <= '0;
    end else begin
      s1_valid <= acc;
      if (clearing) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == AW'(ENTRIES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (s1_valid && (s1_type == REQ_ASSIGN)) begin
        base <= s1_value;
        if (epoch == EPOCH_MAX) begin
          epoch      <= EPOCH_FIRST;
          clearing   <= 1'b1;
          sweep_addr <= '0;
        end else begin
          epoch <= epoch + 1'b1;
        end
      end
    end
  end

  assign status.clearing     = clearing;
  assign status.wrap_hold    = s1_valid && (s1_type == REQ_ASSIGN) && (epoch == EPOCH_MAX);
  assign status.read_pending = res_valid;

endmodule

// File: rtl/core/table_with_bulk_assign_and_point_add.sv
// ----------------------------------------------------------------------------
// table_with_bulk_assign_and_point_add
// Table of signed 64-bit entries with assign-all, point add, load and read.
// ----------------------------------------------------------------------------
// a read result is registered in the core's stage, then written to the result queue that drives m_tdata
// throughput: one request per cycle while no sweep, epoch wrap or full result queue holds s_tready low
// after reset a tag sweep holds s_tready low while it marks every entry dead
// the same sweep runs again after every 255th assign-all request
// reset (rst, synchronous) zeroes the base and marks every entry dead
module table_with_bulk_assign_and_point_add #(
  parameter int ENTRIES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [9:0] index, [73:10] value, [79:74] zero
  input  logic [twba_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] req_type
  input  logic [twba_pkg::REQ_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [63:0] read_value
  output logic [twba_pkg::VALUE_W-1:0]   m_tdata
);
  import twba_pkg::*;

  req_t               req;
  logic               acc;
  logic               res_valid;
  logic [VALUE_W-1:0] res_value;
  core_status_t       status;
  logic [CNT_W-1:0]   count;

  // request unpacking
  assign req.req_type = s_tuser;
  assign req.index    = s_tdata[INDEX_W-1:0];
  assign req.value    = s_tdata[INDEX_W +: VALUE_W];

  // take a request when no sweep or epoch wrap holds the core and the queue has room for every result in flight
  assign s_tready = !status.clearing && !status.wrap_hold &&
                    ((count + CNT_W'(status.read_pending)) <= CNT_W'(OUT_DEPTH - 1));
  assign acc      = s_tvalid && s_tready;

  twba_core #(
    .ENTRIES (ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .req       (req),
    .res_valid (res_valid),
    .res_value (res_value),
    .status    (status)
  );

  twba_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_value),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .count     (count)
  );

endmodule

// File: tb/table_with_bulk_assign_and_point_add_tb.sv
// ----------------------------------------------------------------------------
// table_with_bulk_assign_and_point_add_tb
// Self-checking bench for the table with bulk assign and point add. A driver
// streams load, assign-all, add and read requests from a pending queue, and a
// monitor tracks every accepted request in a table model and checks each read
// result against the oldest predicted value. A long assign-heavy stretch walks
// the block through its epoch wrap and the sweep that follows it.
// ----------------------------------------------------------------------------
module table_with_bulk_assign_and_point_add_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twba_pkg::*;

  localparam int TABLE_SIZE   = 1024;
  localparam int PAD_W        = S_TDATA_W - INDEX_W - VALUE_W;
  localparam int ASSIGN_GOAL  = 300;

  typedef struct {
    bit                 pause;
    int                 snd_idle;
    int                 rcv_idle;
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } stim_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [VALUE_W-1:0]   m_tdata;

  stim_t              pending_q[$];
  logic [VALUE_W-1:0] read_values_q[$];
  logic               results_idle = 1'b1;
  int                 snd_idle_pct = 19;
  int                 rcv_idle_pct = 78;
  int                 fail_count = 0;
  int                 assigns_queued = 0;

  // table model: offset per entry, live flags and the shared base
  logic [VALUE_W-1:0] offset_mem[TABLE_SIZE];
  bit                 live_bits[TABLE_SIZE];
  logic [VALUE_W-1:0] base_word;

  table_with_bulk_assign_and_point_add u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // run limit
  initial begin
    #400000;
    $display("** table_with_bulk_assign_and_point_add: FAILED **");
    $finish;
  end

  // apply one accepted request to the model, predicting a read's value
  function automatic void update_table(logic [REQ_W-1:0] op, logic [INDEX_W-1:0] idx,
                                       logic [VALUE_W-1:0] val);
    bit hit;
    hit = int'(idx) < TABLE_SIZE;
    case (op)
      REQ_LOAD: begin
        if (hit) begin
          offset_mem[idx] = val;
          live_bits[idx]  = 1'b1;
        end
      end
      REQ_ASSIGN: begin
        base_word = val;
        foreach (live_bits[i]) live_bits[i] = 1'b0;
      end
      REQ_ADD: begin
        if (hit) begin
          if (!live_bits[idx]) offset_mem[idx] = '0;
          live_bits[idx]  = 1'b1;
          offset_mem[idx] = offset_mem[idx] + val;
        end
      end
      default: begin
        if (hit && live_bits[idx]) read_values_q.push_back(base_word + offset_mem[idx]);
        else read_values_q.push_back(base_word);
      end
    endcase
  endfunction

  function automatic void note_failure(string what, logic [VALUE_W-1:0] want,
                                       logic [VALUE_W-1:0] got);
    fail_count++;
    if (fail_count <= 10) $display("%s: expected %h got %h", what, want, got);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_q.size() != 0 && pending_q[0].pause) begin
        // hold off until every read result is back, then switch idle rates
        if (!s_tvalid && results_idle) begin
          snd_idle_pct <= pending_q[0].snd_idle;
          rcv_idle_pct <= pending_q[0].rcv_idle;
          void'(pending_q.pop_front());
        end
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, pending_q[0].value, pending_q[0].index};
        s_tuser  <= pending_q[0].req_type;
        void'(pending_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and request tracking
  always @(posedge clk) begin
    logic [VALUE_W-1:0] want;
    if (rst) begin
      m_tready     <= 1'b0;
      results_idle <= 1'b1;
      base_word = '0;
      foreach (live_bits[i]) live_bits[i] = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (read_values_q.size() == 0) begin
          note_failure("read result with none pending", '0, m_tdata);
        end else begin
          want = read_values_q.pop_front();
          if (m_tdata !== want) note_failure("read_value mismatch", want, m_tdata);
        end
      end
      if (s_tvalid && s_tready)
        update_table(s_tuser, s_tdata[INDEX_W-1:0], s_tdata[INDEX_W +: VALUE_W]);
      m_tready     <= ($urandom_range(0, 99) >= rcv_idle_pct);
      results_idle <= (read_values_q.size() == 0);
    end
  end

  // stimulus helpers
  function automatic void queue_req(logic [REQ_W-1:0] op, logic [INDEX_W-1:0] idx,
                                    logic [VALUE_W-1:0] val);
    stim_t s;
    s.pause    = 1'b0;
    s.snd_idle = 0;
    s.rcv_idle = 0;
    s.req_type = op;
    s.index    = idx;
    s.value    = val;
    pending_q.push_back(s);
    if (op == REQ_ASSIGN) assigns_queued++;
  endfunction

  function automatic void queue_pause(int snd, int rcv);
    stim_t s;
    s.pause    = 1'b1;
    s.snd_idle = snd;
    s.rcv_idle = rcv;
    s.req_type = REQ_READ;
    s.index    = '0;
    s.value    = '0;
    pending_q.push_back(s);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2: v = '1;
      3, 4: v = VALUE_W'(int'($urandom_range(0, 64)) - 32);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // mostly a small hot set at both ends of the table so reads hit live entries
  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return INDEX_W'($urandom_range(0, TABLE_SIZE - 1));
    return {($urandom_range(0, 1) != 0) ? 7'h7F : 7'h00, 3'($urandom_range(0, 7))};
  endfunction

  function automatic void queue_random(int count, int assign_pct);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < assign_pct) begin
        queue_req(REQ_ASSIGN, '0, pick_value());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) queue_req(REQ_LOAD, pick_index(), pick_value());
        else if (r < 60) queue_req(REQ_ADD, pick_index(), pick_value());
        else queue_req(REQ_READ, pick_index(), {$urandom, $urandom});
      end
    end
  endfunction

  // stimulus and end of run
  initial begin
    // reads of never-written entries return the base
    queue_req(REQ_READ, 10'd0, '0);
    queue_req(REQ_READ, 10'd1023, '1);
    // load the largest positive value, then add across the wrap
    queue_req(REQ_LOAD, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_req(REQ_READ, 10'd0, '0);
    queue_req(REQ_ADD, 10'd0, 64'd1);
    queue_req(REQ_READ, 10'd0, '0);
    // add to a dead entry starts from zero
    queue_req(REQ_ADD, 10'd1023, 64'h8000_0000_0000_0000);
    queue_req(REQ_READ, 10'd1023, '0);
    // assign-all kills live entries
    queue_req(REQ_LOAD, 10'h155, '1);
    queue_req(REQ_ASSIGN, 10'h2AA, 64'h8000_0000_0000_0000);
    queue_req(REQ_READ, 10'h155, '0);
    queue_req(REQ_READ, 10'd0, '0);
    queue_req(REQ_ADD, 10'h155, '1);
    queue_req(REQ_READ, 10'h155, '0);
    // load after assign is an offset on the new base
    queue_req(REQ_LOAD, 10'h2AA, 64'h5555_5555_5555_5555);
    queue_req(REQ_ASSIGN, 10'd0, '1);
    queue_req(REQ_LOAD, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(REQ_READ, 10'h2AA, '0);
    // back-to-back adds to one entry
    queue_req(REQ_ADD, 10'd3, 64'd5);
    queue_req(REQ_ADD, 10'd3, 64'd7);
    queue_req(REQ_READ, 10'd3, '0);
    queue_req(REQ_ASSIGN, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_req(REQ_READ, 10'd3, '0);

    queue_random(120, 8);
    queue_pause(78, 19);
    queue_random(120, 8);
    queue_pause(0, 0);
    queue_random(120, 8);
    // assign-heavy stretch to force the epoch wrap and its sweep
    while (assigns_queued < ASSIGN_GOAL) queue_random(1, 90);
    queue_random(40, 5);

    do @(negedge clk); while (rst || pending_q.size() != 0 || s_tvalid || !results_idle);
    repeat (20) @(negedge clk);
    if (read_values_q.size() != 0) begin
      fail_count++;
      $display("%0d read results never arrived", read_values_q.size());
    end
    if (fail_count == 0) begin
      $display("** table_with_bulk_assign_and_point_add: PASSED **");
    end else begin
      $display("** table_with_bulk_assign_and_point_add: FAILED **");
    end
    $finish;
  end

endmodule
